[sv/mqm_pkg.sv]
`default_nettype none

package mqm_pkg;

	// Field widths fixed by the request and result formats
	localparam int OP_W  = 3;
	localparam int Q_W   = 5;
	localparam int MSG_W = 32;
	localparam int CAP_W = 5;
	localparam int PID_W = 5;
	localparam int ST_W  = 3;

	// Default sizing
	localparam int DEF_NUM_QUEUES      = 32;
	localparam int DEF_SLOTS_PER_QUEUE = 16;
	localparam int DEF_MSG_WIDTH       = 32;

	// Free-queue search width per cycle
	localparam int SCAN_CHUNK = 32;

	// Request codes
	localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
	localparam logic [OP_W-1:0] OP_SEND    = 3'd1;
	localparam logic [OP_W-1:0] OP_JAM     = 3'd2;
	localparam logic [OP_W-1:0] OP_RECV    = 3'd3;
	localparam logic [OP_W-1:0] OP_DESTROY = 3'd4;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_INVALID = 3'd1;
	localparam logic [ST_W-1:0] ST_DENIED  = 3'd2;
	localparam logic [ST_W-1:0] ST_NOFREE  = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd5;
	localparam logic [ST_W-1:0] ST_BLOCK   = 3'd6;

endpackage

`default_nettype wire

[sv/multi_queue_mailbox.sv]
`default_nettype none

// Channel    | valid      | stall      | payload
// request    | req_valid  | req_stall  | op, queue_sel, message, capacity, caller_pid,
//            |            |            | nonblocking, skip_owner_check
// response   | rsp_valid  | rsp_stall  | status, queue_out, message_out
//
// One request is in flight at a time; the queue table is read on the transfer edge.
// Send, jam, destroy and rejected requests finish in the table state; receive adds one
// message store read state; create runs a free-queue scan through the table and find states,
// 32 queues a cycle. A stalled response holds in the output register; the block then
// finishes the next request into a holding register and waits there.
// Reset (arst_n low) frees every queue at once through the allocation bits.

module multi_queue_mailbox #(
	parameter int NUM_QUEUES      = mqm_pkg::DEF_NUM_QUEUES,
	parameter int SLOTS_PER_QUEUE = mqm_pkg::DEF_SLOTS_PER_QUEUE,
	parameter int MSG_WIDTH       = mqm_pkg::DEF_MSG_WIDTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire logic [mqm_pkg::OP_W-1:0]   op,
	input  wire logic [mqm_pkg::Q_W-1:0]    queue_sel,
	input  wire logic [mqm_pkg::MSG_W-1:0]  message,
	input  wire logic [mqm_pkg::CAP_W-1:0]  capacity,
	input  wire logic [mqm_pkg::PID_W-1:0]  caller_pid,
	input  wire logic                       nonblocking,
	input  wire logic                       skip_owner_check,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output logic [mqm_pkg::ST_W-1:0]        status,
	output logic [mqm_pkg::Q_W-1:0]         queue_out,
	output logic [mqm_pkg::MSG_W-1:0]       message_out
);
	import mqm_pkg::*;

	localparam int QW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int SW         = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
	localparam int HW         = ((SW > CAP_W) ? SW : CAP_W) + 1;
	localparam int DEPTH      = NUM_QUEUES * SLOTS_PER_QUEUE;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CHUNK      = (NUM_QUEUES < SCAN_CHUNK) ? NUM_QUEUES : SCAN_CHUNK;
	localparam int NUM_CHUNKS = (NUM_QUEUES + CHUNK - 1) / CHUNK;
	localparam int PADW       = NUM_CHUNKS * CHUNK;
	localparam int CW         = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int PW         = (CHUNK > 1) ? $clog2(CHUNK) : 1;

	typedef struct packed {
		logic [CAP_W-1:0] cap;
		logic [CAP_W-1:0] used;
		logic [SW-1:0]    head;
		logic [PID_W-1:0] owner;
	} qent_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_TAB  = 5'b00010,
		S_FIND = 5'b00100,
		S_MSG  = 5'b01000,
		S_PUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Request fields held for the request in flight
	logic [OP_W-1:0]  op_s1;
	logic [QW-1:0]    qidx_s1;
	logic             qok_s1;
	logic [MSG_WIDTH-1:0] msg_s1;
	logic [CAP_W-1:0] cap_s1;
	logic [PID_W-1:0] pid_s1;
	logic             nb_s1;
	logic             skip_s1;

	// Memories and their ports
	qent_t                qtab_mem [NUM_QUEUES];
	logic [MSG_WIDTH-1:0] msg_mem  [DEPTH];
	qent_t                tab_rd_s1;
	logic [MSG_WIDTH-1:0] msg_rd_s2;
	logic                 tab_we;
	logic [QW-1:0]        tab_wa;
	qent_t                tab_wd;
	logic                 msg_we;
	logic                 msg_re;
	logic [AW-1:0]        msg_addr;

	// Allocation bits; padding above NUM_QUEUES stays set
	logic [PADW-1:0] alloc_q;
	logic            alloc_set;
	logic            alloc_clr;
	logic [QW-1:0]   alloc_idx;

	logic [CW-1:0]   chunk_q;
	logic            chunk_inc;

	logic            acc;
	logic            out_free;
	logic            fin;
	logic            fin_load;
	logic [ST_W-1:0]  fin_status;
	logic [Q_W-1:0]   fin_queue;
	logic [MSG_W-1:0] fin_msg;
	logic            go_find;
	logic            go_msg;

	logic [ST_W-1:0]  pend_status_q;
	logic [Q_W-1:0]   pend_queue_q;
	logic [MSG_W-1:0] pend_msg_q;

	logic            rsp_valid_q;
	logic [ST_W-1:0]  status_q;
	logic [Q_W-1:0]   queue_out_q;
	logic [MSG_W-1:0] message_out_q;

	logic            do_search;
	logic            cap_bad;
	logic [CHUNK-1:0] free_bits;
	logic            found_any;
	logic [PW-1:0]   found_pos;
	logic [QW-1:0]   found_idx;
	logic            last_chunk;

	logic [HW-1:0]   c_w, u_w, h_w;
	logic [HW-1:0]   tail_w, jam_w, rcv_w;
	logic [SW-1:0]   slot;

	assign acc       = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign fin_load  = fin && out_free;

	// Capture the request and read its queue entry
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= op;
			qidx_s1   <= QW'(queue_sel);
			qok_s1    <= (int'(queue_sel) < NUM_QUEUES);
			msg_s1    <= MSG_WIDTH'(message);
			cap_s1    <= capacity;
			pid_s1    <= caller_pid;
			nb_s1     <= nonblocking;
			skip_s1   <= skip_owner_check;
			tab_rd_s1 <= qtab_mem[QW'(queue_sel)];
		end
	end

	// Queue table write port
	always_ff @(posedge clk) begin
		if (tab_we) begin
			qtab_mem[tab_wa] <= tab_wd;
		end
	end

	// Message store: one port, read or write
	always_ff @(posedge clk) begin
		if (msg_we) begin
			msg_mem[msg_addr] <= msg_s1;
		end
		if (msg_re) begin
			msg_rd_s2 <= msg_mem[msg_addr];
		end
	end

	// Lowest free queue within the current chunk
	assign free_bits  = ~alloc_q[chunk_q*CHUNK +: CHUNK];
	assign found_any  = |free_bits;
	assign last_chunk = (int'(chunk_q) == NUM_CHUNKS - 1);
	assign found_idx  = QW'(int'(chunk_q) * CHUNK + int'(found_pos));

	always_comb begin
		found_pos = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				found_pos = PW'(i);
			end
		end
	end

	// Ring arithmetic on the entry read for this request
	always_comb begin
		c_w    = HW'(tab_rd_s1.cap);
		u_w    = HW'(tab_rd_s1.used);
		h_w    = HW'(tab_rd_s1.head);
		tail_w = h_w + u_w;
		if (tail_w >= c_w) begin
			tail_w = tail_w - c_w;
		end
		jam_w = (h_w == '0) ? c_w - HW'(1) : h_w - HW'(1);
		rcv_w = h_w + HW'(1);
		if (rcv_w >= c_w) begin
			rcv_w = rcv_w - c_w;
		end
	end

	always_comb begin
		case (op_s1)
			OP_SEND: slot = SW'(tail_w);
			OP_JAM:  slot = SW'(jam_w);
			default: slot = tab_rd_s1.head;
		endcase
	end

	assign msg_addr = AW'(AW'(qidx_s1) * AW'(SLOTS_PER_QUEUE)) + AW'(slot);

	assign cap_bad   = (cap_s1 == '0) || (int'(cap_s1) > SLOTS_PER_QUEUE);
	assign do_search = (state_q == S_FIND) ||
		((state_q == S_TAB) && (op_s1 == OP_CREATE) && !cap_bad);

	// Decide the request: memory updates and the result
	always_comb begin
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_queue  = '0;
		fin_msg    = '0;
		tab_we     = 1'b0;
		tab_wa     = qidx_s1;
		tab_wd     = tab_rd_s1;
		msg_we     = 1'b0;
		msg_re     = 1'b0;
		alloc_set  = 1'b0;
		alloc_clr  = 1'b0;
		alloc_idx  = qidx_s1;
		chunk_inc  = 1'b0;
		go_find    = 1'b0;
		go_msg     = 1'b0;

		if (do_search) begin
			if (found_any) begin
				tab_we       = 1'b1;
				tab_wa       = found_idx;
				tab_wd.cap   = cap_s1;
				tab_wd.used  = '0;
				tab_wd.head  = '0;
				tab_wd.owner = pid_s1;
				alloc_set    = 1'b1;
				alloc_idx    = found_idx;
				fin          = 1'b1;
				fin_queue    = Q_W'(found_idx);
			end else if (last_chunk) begin
				fin        = 1'b1;
				fin_status = ST_NOFREE;
			end else begin
				chunk_inc = 1'b1;
				go_find   = 1'b1;
			end
		end else begin
			case (state_q)
				S_TAB: begin
					if (op_s1 == OP_CREATE || op_s1 > OP_DESTROY || !qok_s1 ||
						!alloc_q[qidx_s1]) begin
						// bad capacity, unknown request, out of range or free queue
						fin        = 1'b1;
						fin_status = ST_INVALID;
					end else if (!skip_s1 && tab_rd_s1.owner != pid_s1) begin
						fin        = 1'b1;
						fin_status = ST_DENIED;
					end else begin
						case (op_s1)
							OP_SEND, OP_JAM: begin
								fin = 1'b1;
								if (u_w >= c_w) begin
									fin_status = nb_s1 ? ST_FULL : ST_BLOCK;
								end else begin
									msg_we      = 1'b1;
									tab_we      = 1'b1;
									tab_wd.used = CAP_W'(u_w + HW'(1));
									if (op_s1 == OP_JAM) begin
										tab_wd.head = SW'(jam_w);
									end
								end
							end
							OP_RECV: begin
								if (u_w == '0) begin
									fin        = 1'b1;
									fin_status = nb_s1 ? ST_EMPTY : ST_BLOCK;
								end else begin
									msg_re      = 1'b1;
									tab_we      = 1'b1;
									tab_wd.used = CAP_W'(u_w - HW'(1));
									tab_wd.head = SW'(rcv_w);
									go_msg      = 1'b1;
								end
							end
							default: begin
								alloc_clr = 1'b1;
								fin       = 1'b1;
							end
						endcase
					end
				end
				S_MSG: begin
					fin     = 1'b1;
					fin_msg = MSG_W'(msg_rd_s2);
				end
				S_PUT: begin
					fin        = 1'b1;
					fin_status = pend_status_q;
					fin_queue  = pend_queue_q;
					fin_msg    = pend_msg_q;
				end
				default: begin
					fin = 1'b0;
				end
			endcase
		end
	end

	// Sequence the request
	always_comb begin
		state_d = state_q;
		if (state_q == S_IDLE) begin
			if (acc) begin
				state_d = S_TAB;
			end
		end else if (fin) begin
			state_d = out_free ? S_IDLE : S_PUT;
		end else if (go_find) begin
			state_d = S_FIND;
		end else if (go_msg) begin
			state_d = S_MSG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			chunk_q     <= '0;
			for (int i = 0; i < PADW; i++) begin
				alloc_q[i] <= (i >= NUM_QUEUES);
			end
		end else begin
			state_q <= state_d;
			// restart the free-queue scan on each transfer
			if (acc) begin
				chunk_q <= '0;
			end else if (chunk_inc) begin
				chunk_q <= chunk_q + CW'(1);
			end
			if (alloc_set) begin
				alloc_q[alloc_idx] <= 1'b1;
			end else if (alloc_clr) begin
				alloc_q[alloc_idx] <= 1'b0;
			end
			// hold the response until its transfer
			if (fin_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response register and holding register
	always_ff @(posedge clk) begin
		if (fin_load) begin
			status_q      <= fin_status;
			queue_out_q   <= fin_queue;
			message_out_q <= fin_msg;
		end
		if (fin && !out_free) begin
			pend_status_q <= fin_status;
			pend_queue_q  <= fin_queue;
			pend_msg_q    <= fin_msg;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign queue_out   = queue_out_q;
	assign message_out = message_out_q;

	// Checks
	a_alloc_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(alloc_set && alloc_clr))
		else $error("queue allocated and freed in one cycle");

	a_msg_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_we && msg_re))
		else $error("message store read and written in one cycle");

	a_alloc_mark: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_set |=> alloc_q[$past(alloc_idx)])
		else $error("created queue not marked allocated");

	a_msg_from_recv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MSG) |-> ($past(state_q) == S_TAB && op_s1 == OP_RECV))
		else $error("message read stage entered without a receive");

endmodule

`default_nettype wire

[tb/mqm_result_checker.sv]
`timescale 1ns / 1ps

module mqm_result_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	input  wire logic                              req_stall,
	input  wire logic [mqm_pkg::OP_W-1:0]          op,
	input  wire logic [mqm_pkg::Q_W-1:0]           queue_sel,
	input  wire logic [mqm_pkg::MSG_W-1:0]         message,
	input  wire logic [mqm_pkg::CAP_W-1:0]         capacity,
	input  wire logic [mqm_pkg::PID_W-1:0]         caller_pid,
	input  wire logic                              nonblocking,
	input  wire logic                              skip_owner_check,
	input  wire logic                              rsp_valid,
	input  wire logic                              rsp_stall,
	input  wire logic [mqm_pkg::ST_W-1:0]          status,
	input  wire logic [mqm_pkg::Q_W-1:0]           queue_out,
	input  wire logic [mqm_pkg::MSG_W-1:0]         message_out,
	output int                                     fail_count,
	output int                                     outstanding,
	output int                                     checked,
	output logic [7:0]                             status_seen,
	output logic [31:0][mqm_pkg::CAP_W-1:0]        cap_view,
	output logic [31:0][mqm_pkg::CAP_W-1:0]        used_view,
	output logic [31:0][mqm_pkg::PID_W-1:0]        owner_view
);
	import mqm_pkg::*;

	localparam int NQ    = DEF_NUM_QUEUES;
	localparam int SLOTS = DEF_SLOTS_PER_QUEUE;

	typedef struct packed {
		logic [ST_W-1:0]  st;
		logic [Q_W-1:0]   qid;
		logic [MSG_W-1:0] word;
	} mbx_result_t;

	// mailbox tables as the block should hold them
	logic [31:0][CAP_W-1:0] qcap;
	logic [31:0][CAP_W-1:0] qused;
	logic [31:0][3:0]       qhead;
	logic [31:0][PID_W-1:0] qowner;
	logic [MSG_W-1:0]       msg_mem [0:NQ*SLOTS-1];

	mbx_result_t awaited_results[$];
	int          errors;
	int          n_checked;
	logic [7:0]  seen;

	initial begin
		fail_count  = 0;
		outstanding = 0;
		checked     = 0;
		status_seen = '0;
		cap_view    = '0;
		used_view   = '0;
		owner_view  = '0;
		errors      = 0;
		n_checked   = 0;
		seen        = '0;
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= 30)
			$display("%0t: response %0d: %s is 0x%0h, expected 0x%0h",
				$realtime, n_checked, field, got, want);
	endtask

	// work out the result of one request and update the tables
	task automatic mailbox_step(input logic [OP_W-1:0] rop, input logic [Q_W-1:0] rq,
			input logic [MSG_W-1:0] rmsg, input logic [CAP_W-1:0] rcap,
			input logic [PID_W-1:0] rpid, input logic rnb, input logic rskip,
			output mbx_result_t r);
		int i;
		int c;
		int u;
		int h;
		int slot;
		r = '0;
		r.st = ST_OK;
		if (rop == OP_CREATE) begin
			if (rcap == 0 || rcap > SLOTS) begin
				r.st = ST_INVALID;
			end else begin
				i = 0;
				while (i < NQ && qcap[i] != 0)
					i++;
				if (i >= NQ) begin
					r.st = ST_NOFREE;
				end else begin
					qcap[i]   = rcap;
					qused[i]  = '0;
					qhead[i]  = '0;
					qowner[i] = rpid;
					r.qid     = Q_W'(i);
				end
			end
		end else if (rop > OP_DESTROY || int'(rq) >= NQ || qcap[rq] == 0) begin
			r.st = ST_INVALID;
		end else if (!rskip && qowner[rq] != rpid) begin
			r.st = ST_DENIED;
		end else begin
			c = qcap[rq];
			u = qused[rq];
			h = qhead[rq];
			case (rop)
				OP_SEND, OP_JAM: begin
					if (u >= c) begin
						r.st = rnb ? ST_FULL : ST_BLOCK;
					end else if (rop == OP_SEND) begin
						slot = h + u;
						if (slot >= c)
							slot -= c;
						msg_mem[rq * SLOTS + slot] = rmsg;
						qused[rq] = CAP_W'(u + 1);
					end else begin
						// jam steps the head back, wrapping to the last slot
						h = (h == 0) ? c - 1 : h - 1;
						qhead[rq] = 4'(h);
						msg_mem[rq * SLOTS + h] = rmsg;
						qused[rq] = CAP_W'(u + 1);
					end
				end
				OP_RECV: begin
					if (u == 0) begin
						r.st = rnb ? ST_EMPTY : ST_BLOCK;
					end else begin
						r.word = msg_mem[rq * SLOTS + h];
						h = h + 1;
						if (h >= c)
							h -= c;
						qhead[rq] = 4'(h);
						qused[rq] = CAP_W'(u - 1);
					end
				end
				default: begin
					qcap[rq]  = '0;
					qused[rq] = '0;
					qhead[rq] = '0;
				end
			endcase
		end
	endtask

	// compare response transfers, then predict request transfers
	always @(posedge clk or negedge arst_n) begin
		mbx_result_t want;
		mbx_result_t fresh;
		if (!arst_n) begin
			qcap   = '0;
			qused  = '0;
			qhead  = '0;
			qowner = '0;
			awaited_results.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("status of unrequested response", 32'(status), 32'(0));
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (queue_out !== want.qid)
						report_mismatch("queue_out", 32'(queue_out), 32'(want.qid));
					if (message_out !== want.word)
						report_mismatch("message_out", message_out, want.word);
					seen[want.st] = 1'b1;
				end
				n_checked++;
			end
			if (req_valid && !req_stall) begin
				mailbox_step(op, queue_sel, message, capacity, caller_pid,
					nonblocking, skip_owner_check, fresh);
				awaited_results.push_back(fresh);
			end
		end
		fail_count  <= errors;
		outstanding <= awaited_results.size();
		checked     <= n_checked;
		status_seen <= seen;
		cap_view    <= qcap;
		used_view   <= qused;
		owner_view  <= qowner;
	end

endmodule

[tb/tb_multi_queue_mailbox.sv]
`timescale 1ns / 1ps

module tb_multi_queue_mailbox;
	import mqm_pkg::*;

	localparam int RAND_ITEMS  = 925;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [OP_W-1:0]  OP_RSVD_FIRST = OP_DESTROY + 3'd1;
	localparam logic [PID_W-1:0] PID_HI        = 5'd31;
	localparam logic [PID_W-1:0] PID_LO        = 5'd0;
	localparam logic [PID_W-1:0] PID_STRANGER  = 5'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [OP_W-1:0]     op = '0;
	logic [Q_W-1:0]      queue_sel = '0;
	logic [MSG_W-1:0]    message = '0;
	logic [CAP_W-1:0]    capacity = '0;
	logic [PID_W-1:0]    caller_pid = '0;
	logic                nonblocking = 1'b0;
	logic                skip_owner_check = 1'b0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [ST_W-1:0]     status;
	logic [Q_W-1:0]      queue_out;
	logic [MSG_W-1:0]    message_out;

	int                  fail_count;
	int                  outstanding;
	int                  checked;
	logic [7:0]          status_seen;
	logic [31:0][CAP_W-1:0] cap_view;
	logic [31:0][CAP_W-1:0] used_view;
	logic [31:0][PID_W-1:0] owner_view;

	int cycle_cnt = 0;
	int sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	multi_queue_mailbox dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.op               (op),
		.queue_sel        (queue_sel),
		.message          (message),
		.capacity         (capacity),
		.caller_pid       (caller_pid),
		.nonblocking      (nonblocking),
		.skip_owner_check (skip_owner_check),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.status           (status),
		.queue_out        (queue_out),
		.message_out      (message_out)
	);

	mqm_result_checker mailbox_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.op               (op),
		.queue_sel        (queue_sel),
		.message          (message),
		.capacity         (capacity),
		.caller_pid       (caller_pid),
		.nonblocking      (nonblocking),
		.skip_owner_check (skip_owner_check),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.status           (status),
		.queue_out        (queue_out),
		.message_out      (message_out),
		.fail_count       (fail_count),
		.outstanding      (outstanding),
		.checked          (checked),
		.status_seen      (status_seen),
		.cap_view         (cap_view),
		.used_view        (used_view),
		.owner_view       (owner_view)
	);

	// give up on a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_cnt, outstanding);
			$display("[multi_queue_mailbox] ERROR");
			$finish;
		end
	end

	// receiver back-pressure: switch among five stall patterns at random
	int stall_mode = 0;
	int mode_left = 0;
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 4);
			mode_left  <= $urandom_range(50, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			3: rsp_stall <= ((cycle_cnt % 7) < 3);
			4: rsp_stall <= ($urandom_range(0, 15) != 0);
			default: rsp_stall <= 1'b0;
		endcase
	end

	// present one request and hold it until its transfer
	task automatic issue(input logic [OP_W-1:0] o, input logic [Q_W-1:0] q,
			input logic [MSG_W-1:0] m, input logic [CAP_W-1:0] c,
			input logic [PID_W-1:0] p, input logic nb, input logic sk);
		op               <= o;
		queue_sel        <= q;
		message          <= m;
		capacity         <= c;
		caller_pid       <= p;
		nonblocking      <= nb;
		skip_owner_check <= sk;
		req_valid        <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic idle_for(input int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every outstanding response has been seen
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int burst_left;
		int gap;
		int n;
		int k;
		int live_cnt;
		int held;
		int pick;
		logic [Q_W-1:0]   live [32];
		logic [OP_W-1:0]  r_op;
		logic [Q_W-1:0]   r_q;
		logic [CAP_W-1:0] r_cap;
		logic [PID_W-1:0] r_pid;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejects, limits, wrap-around and ownership
		issue(OP_CREATE, 5'd0, 32'h0, 5'd0, PID_HI, 1'b1, 1'b0);
		issue(OP_CREATE, 5'd0, 32'h0, 5'd17, PID_HI, 1'b1, 1'b0);
		issue(OP_CREATE, 5'd0, 32'h0, 5'd31, PID_HI, 1'b1, 1'b0);
		issue(OP_SEND, 5'd31, 32'h1234_5678, 5'd0, PID_LO, 1'b1, 1'b1);
		for (k = int'(OP_RSVD_FIRST); k <= 7; k++)
			issue(OP_W'(k), 5'd0, 32'h0, 5'd4, PID_LO, 1'b1, 1'b1);
		issue(OP_CREATE, 5'd0, 32'h0, 5'd1, PID_HI, 1'b0, 1'b0);
		issue(OP_CREATE, 5'd0, 32'h0, 5'd16, PID_LO, 1'b0, 1'b0);
		issue(OP_SEND, 5'd0, 32'hFFFF_FFFF, 5'd0, PID_HI, 1'b1, 1'b0);
		issue(OP_SEND, 5'd0, 32'h5555_5555, 5'd0, PID_HI, 1'b1, 1'b0);
		issue(OP_SEND, 5'd0, 32'h5555_5555, 5'd0, PID_HI, 1'b0, 1'b0);
		issue(OP_JAM, 5'd0, 32'hAAAA_AAAA, 5'd0, PID_STRANGER, 1'b1, 1'b0);
		issue(OP_JAM, 5'd0, 32'hAAAA_AAAA, 5'd0, PID_STRANGER, 1'b1, 1'b1);
		issue(OP_RECV, 5'd0, 32'h0, 5'd0, PID_HI, 1'b1, 1'b0);
		issue(OP_RECV, 5'd0, 32'h0, 5'd0, PID_HI, 1'b1, 1'b0);
		issue(OP_RECV, 5'd0, 32'h0, 5'd0, PID_HI, 1'b0, 1'b0);
		issue(OP_JAM, 5'd1, 32'h0000_0000, 5'd0, PID_LO, 1'b0, 1'b0);
		issue(OP_SEND, 5'd1, 32'hA5A5_A5A5, 5'd0, PID_LO, 1'b0, 1'b0);
		issue(OP_RECV, 5'd1, 32'h0, 5'd0, PID_LO, 1'b0, 1'b0);
		issue(OP_RECV, 5'd1, 32'h0, 5'd0, PID_LO, 1'b0, 1'b0);
		issue(OP_DESTROY, 5'd0, 32'h0, 5'd0, 5'd3, 1'b0, 1'b0);
		issue(OP_DESTROY, 5'd0, 32'h0, 5'd0, PID_HI, 1'b0, 1'b0);
		issue(OP_RECV, 5'd0, 32'h0, 5'd0, PID_HI, 1'b1, 1'b1);
		issue(OP_CREATE, 5'd0, 32'h0, 5'd16, 5'd21, 1'b0, 1'b0);
		drain();

		// random traffic, mostly aimed at live queues by their owners
		burst_left = 0;
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0)
					idle_for(gap);
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
			if (n == RAND_ITEMS / 2)
				drain();

			live_cnt = 0;
			for (k = 0; k < 32; k++)
				if (cap_view[k] != 0) begin
					live[live_cnt] = Q_W'(k);
					live_cnt++;
				end

			pick = $urandom_range(0, 99);
			if (pick < 12)
				r_op = OP_CREATE;
			else if (pick < 40)
				r_op = OP_SEND;
			else if (pick < 54)
				r_op = OP_JAM;
			else if (pick < 82)
				r_op = OP_RECV;
			else if (pick < 96 && (pick < 88 || live_cnt >= 28))
				r_op = OP_DESTROY;
			else if (pick < 96)
				r_op = OP_RECV;
			else
				r_op = OP_W'($urandom_range(int'(OP_RSVD_FIRST), 7));

			if (live_cnt != 0 && $urandom_range(0, 99) < 85)
				r_q = live[$urandom_range(0, live_cnt - 1)];
			else
				r_q = Q_W'($urandom_range(0, 31));

			pick = $urandom_range(0, 99);
			if (pick < 70)
				r_cap = CAP_W'($urandom_range(1, 4));
			else if (pick < 94)
				r_cap = CAP_W'($urandom_range(5, 16));
			else
				r_cap = ($urandom_range(0, 1) == 0) ? '0 : CAP_W'($urandom_range(17, 31));

			if (r_op != OP_CREATE && $urandom_range(0, 99) < 85)
				r_pid = owner_view[r_q];
			else
				r_pid = PID_W'($urandom_range(0, 31));

			issue(r_op, r_q, $urandom, r_cap, r_pid, 1'($urandom_range(0, 1)),
				($urandom_range(0, 4) == 0));
		end

		drain();
		idle_for(10);

		live_cnt = 0;
		held = 0;
		for (k = 0; k < 32; k++)
			if (cap_view[k] != 0) begin
				live_cnt++;
				held += int'(used_view[k]);
			end
		$display("Covered %0d requests and %0d checked responses, %0d queues live holding %0d",
			sent, checked, live_cnt, held);
		$display("Status codes returned (bit per code, ok is bit 0): %b", status_seen[6:0]);
		if (fail_count == 0)
			$display("[multi_queue_mailbox] OK");
		else
			$display("[multi_queue_mailbox] ERROR");
		$finish;
	end

endmodule

[multi_queue_mailbox.f]
sv/mqm_pkg.sv
sv/multi_queue_mailbox.sv
tb/mqm_result_checker.sv
tb/tb_multi_queue_mailbox.sv
